// File: hw/rtl/multiwave_lfo_generator_defines.svh
// ----------------------------------------------------------------------------
// Multiwave LFO assertion macros
// Shared assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef MULTIWAVE_LFO_GENERATOR_DEFINES_SVH
`define MULTIWAVE_LFO_GENERATOR_DEFINES_SVH

// check a property outside reset
`define LFO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge, reset included
`define LFO_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/lfo_pkg.sv
// ----------------------------------------------------------------------------
// LFO package
// Widths, codes, constants and saturation helpers of the multiwave LFO.
// ----------------------------------------------------------------------------
package lfo_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int CHUNK_LOG2 = 4;
   localparam int CHUNK_LEN  = 1 << CHUNK_LOG2;
   localparam int CNT_W      = $clog2(CHUNK_LEN + 1);

   localparam int ST_W    = 20;
   localparam int OUT_W   = 18;
   localparam int DIFF_W  = ST_W + 1;
   localparam int SINE_W  = ST_W + 2;
   localparam int PROD_W  = ST_W + SINE_W;
   localparam int SAT_W   = PROD_W + 2;
   localparam int IPROD_W = DIFF_W + CNT_W + 1;
   localparam int SUM_W   = ST_W + 2;

   localparam int LFSR_W = 16;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   localparam logic signed [ST_W-1:0]   ST_ONE  = ST_W'(64'(1) << FRAC_BITS);
   localparam logic signed [SINE_W-1:0] TWO_ONE = SINE_W'(64'(2) << FRAC_BITS);

   // configuration
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int STEP_W     = 17;
   localparam int WAVE_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SELECT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SEED  = 2'd2;

   localparam logic [STEP_W-1:0] PHASE_STEP_RST = 17'd437;
   localparam logic [WAVE_W-1:0] WAVE_SELECT_RST = 3'd0;
   localparam logic [LFSR_W-1:0] NOISE_SEED_RST = 16'd44257;

   localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [WAVE_W-1:0] WAVE_SAW_UP   = 3'd2;
   localparam logic [WAVE_W-1:0] WAVE_SAW_DOWN = 3'd3;
   localparam logic [WAVE_W-1:0] WAVE_RECT     = 3'd4;
   localparam logic [WAVE_W-1:0] WAVE_HOLD     = 3'd5;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic [1:0] MODE_PASS = 2'd0;
   localparam logic [1:0] MODE_NEG  = 2'd1;
   localparam logic [1:0] MODE_ZERO = 2'd2;

   // queue between front and back, power of two deep
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic signed [ST_W-1:0]   old_value;
      logic signed [DIFF_W-1:0] diff;
      logic [1:0]               mode;
   } lfo_entry_type;

   localparam logic signed [SAT_W-1:0] ST_MAX = SAT_W'((64'(1) << (ST_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0] ST_MIN = -ST_MAX - SAT_W'(1);
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'(1) << (OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);

   function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SAT_W-1:0] v);
      logic signed [ST_W-1:0] r;
      if (v > ST_MAX) begin
         r = ST_MAX[ST_W-1:0];
      end else if (v < ST_MIN) begin
         r = ST_MIN[ST_W-1:0];
      end else begin
         r = v[ST_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[OUT_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/lfo_front.sv
// ----------------------------------------------------------------------------
// LFO front end
// Holds configuration and oscillator state, advances it once per tick and
// forms the ramp of the selected wave for the interpolator.
// ----------------------------------------------------------------------------
module lfo_front import lfo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  accept,
   input  logic                  reset_gate,
   output lfo_entry_type         entry
);

   localparam int N_WAVES  = 5;
   localparam int IDX_SINE = 0;
   localparam int IDX_SAW  = 1;
   localparam int IDX_HOLD = 2;
   localparam int IDX_TRI  = 3;
   localparam int IDX_SQR  = 4;

   logic [STEP_W-1:0]      phase_step_ff;
   logic [WAVE_W-1:0]      wave_select_ff;
   logic [LFSR_W-1:0]      lfsr_ff, lfsr_in;
   logic signed [ST_W-1:0] phase_ff, phase_in;
   logic signed [ST_W-1:0] delta_ff, delta_in;
   logic [1:0]             quad_ff, quad_in;
   logic                   gate_ff;
   logic signed [ST_W-1:0] saw_ff, saw_in;
   logic signed [ST_W-1:0] square_ff, square_in;
   logic signed [ST_W-1:0] hold_ff, hold_in;
   logic signed [ST_W-1:0] sine_in;
   logic signed [ST_W-1:0] old_ff [N_WAVES];

   logic                     rise;
   logic                     draw;
   logic signed [ST_W-1:0]   step_s;
   logic signed [ST_W-1:0]   t;
   logic [1:0]               q0;
   logic signed [ST_W-1:0]   saw_base;
   logic [LFSR_W-1:0]        lfsr_step;
   logic [LFSR_W-1:0]        seed_load;
   logic signed [SINE_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ST_W-1:0]   tgt [N_WAVES];
   logic signed [ST_W-1:0]   old_sel, tgt_sel;
   logic [1:0]               mode_sel;

   always_comb begin
      step_s    = $signed(ST_W'(phase_step_ff));
      rise      = reset_gate & ~gate_ff;
      t         = rise ? '0 : phase_ff;
      q0        = rise ? QUAD_0 : quad_ff;
      delta_in  = rise ? step_s : delta_ff;
      square_in = rise ? -ST_ONE : square_ff;
      saw_base  = saw_ff;
      quad_in   = q0;
      draw      = 1'b0;
      if (t >= ST_ONE) begin
         quad_in  = QUAD_1;
         delta_in = -step_s;
      end else if (t <= -ST_ONE) begin
         quad_in  = QUAD_3;
         delta_in = step_s;
      end else if (q0 == QUAD_1 && t < 0) begin
         quad_in   = QUAD_2;
         square_in = ST_ONE;
         draw      = 1'b1;
      end else if (q0 == QUAD_3 && t > 0) begin
         quad_in   = QUAD_0;
         square_in = -ST_ONE;
         draw      = 1'b1;
         saw_base  = -ST_ONE;
      end

      lfsr_step = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
      hold_in   = draw ? sat_st(((SAT_W'(lfsr_step) <<< (FRAC_BITS + 1)) >>> LFSR_W)
                                - SAT_W'(ST_ONE))
                       : hold_ff;

      if (quad_in == QUAD_2 || quad_in == QUAD_3) begin
         mul_b = TWO_ONE + SINE_W'(t);
      end else begin
         mul_b = TWO_ONE - SINE_W'(t);
      end
      prod     = t * mul_b;
      sine_in  = sat_st(SAT_W'(prod >>> FRAC_BITS));
      saw_in   = sat_st(SAT_W'(saw_base) + SAT_W'(step_s >>> 1));
      phase_in = sat_st(SAT_W'(t) + SAT_W'(delta_in));

      tgt[IDX_SINE] = sine_in;
      tgt[IDX_SAW]  = saw_in;
      tgt[IDX_HOLD] = hold_in;
      tgt[IDX_TRI]  = phase_in;
      tgt[IDX_SQR]  = square_in;

      case (wave_select_ff)
         WAVE_SINE: begin
            old_sel = old_ff[IDX_SINE]; tgt_sel = tgt[IDX_SINE]; mode_sel = MODE_PASS;
         end
         WAVE_TRIANGLE: begin
            old_sel = old_ff[IDX_TRI]; tgt_sel = tgt[IDX_TRI]; mode_sel = MODE_PASS;
         end
         WAVE_SAW_UP: begin
            old_sel = old_ff[IDX_SAW]; tgt_sel = tgt[IDX_SAW]; mode_sel = MODE_PASS;
         end
         WAVE_SAW_DOWN: begin
            old_sel = old_ff[IDX_SAW]; tgt_sel = tgt[IDX_SAW]; mode_sel = MODE_NEG;
         end
         WAVE_RECT: begin
            old_sel = old_ff[IDX_SQR]; tgt_sel = tgt[IDX_SQR]; mode_sel = MODE_NEG;
         end
         WAVE_HOLD: begin
            old_sel = old_ff[IDX_HOLD]; tgt_sel = tgt[IDX_HOLD]; mode_sel = MODE_PASS;
         end
         default: begin
            old_sel = '0; tgt_sel = '0; mode_sel = MODE_ZERO;
         end
      endcase

      entry.old_value = old_sel;
      entry.diff      = DIFF_W'(tgt_sel) - DIFF_W'(old_sel);
      entry.mode      = mode_sel;

      seed_load = csr_data[LFSR_W-1:0];
      if (seed_load == '0) begin
         seed_load = LFSR_W'(1);
      end
      if (csr_we && csr_index == CSR_NOISE_SEED) begin
         lfsr_in = seed_load;
      end else if (accept && draw) begin
         lfsr_in = lfsr_step;
      end else begin
         lfsr_in = lfsr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RST;
         wave_select_ff <= WAVE_SELECT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP:  phase_step_ff  <= csr_data[STEP_W-1:0];
            CSR_WAVE_SELECT: wave_select_ff <= csr_data[WAVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff   <= NOISE_SEED_RST;
         phase_ff  <= '0;
         delta_ff  <= $signed(ST_W'(PHASE_STEP_RST));
         quad_ff   <= QUAD_0;
         gate_ff   <= 1'b0;
         saw_ff    <= -ST_ONE;
         square_ff <= '0;
         hold_ff   <= '0;
         for (int i = 0; i < N_WAVES; i++) begin
            old_ff[i] <= '0;
         end
      end else begin
         lfsr_ff <= lfsr_in;
         if (accept) begin
            phase_ff  <= phase_in;
            delta_ff  <= delta_in;
            quad_ff   <= quad_in;
            gate_ff   <= reset_gate;
            saw_ff    <= saw_in;
            square_ff <= square_in;
            hold_ff   <= hold_in;
            for (int i = 0; i < N_WAVES; i++) begin
               old_ff[i] <= tgt[i];
            end
         end
      end
   end

endmodule

// File: hw/rtl/lfo_fifo.sv
// ----------------------------------------------------------------------------
// LFO ramp queue
// Short queue of ramp descriptors between front and back.
// ----------------------------------------------------------------------------
module lfo_fifo import lfo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  lfo_entry_type din,
   output logic          full,
   input  logic          pop,
   output lfo_entry_type dout,
   output logic          empty
);

   lfo_entry_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;

   assign full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - FIFO_CNT_W'(1);
         end
      end
   end

endmodule

// File: hw/rtl/lfo_back.sv
// ----------------------------------------------------------------------------
// LFO interpolator
// Steps one ramp through its chunk into an output register, one sample per
// cycle while that register is empty or being taken.
// ----------------------------------------------------------------------------
module lfo_back import lfo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  lfo_entry_type           q_entry,
   output logic                    q_pop,
   output logic                    out_valid,
   input  logic                    out_take,
   output logic signed [OUT_W-1:0] out_sample,
   output logic                    out_last
);

   lfo_entry_type           cur_ff;
   logic                    cur_valid_ff;
   logic [CNT_W-1:0]        k_ff;
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_sample_ff;
   logic                    out_last_ff;

   logic                      advance;
   logic                      last;
   logic signed [IPROD_W-1:0] iprod;
   logic signed [IPROD_W-1:0] biased;
   logic signed [SUM_W-1:0]   sum;
   logic signed [OUT_W-1:0]   sample_in;

   always_comb begin
      advance = cur_valid_ff && (!out_valid_ff || out_take);
      last    = (k_ff == CNT_W'(CHUNK_LEN));
      q_pop   = !q_empty && (!cur_valid_ff || (advance && last));

      // quotient rounds toward zero
      iprod  = cur_ff.diff * $signed({1'b0, k_ff});
      biased = iprod + ((iprod < 0) ? IPROD_W'(CHUNK_LEN - 1) : '0);
      sum    = SUM_W'(cur_ff.old_value) + SUM_W'(biased >>> CHUNK_LOG2);
      case (cur_ff.mode)
         MODE_PASS: sample_in = sat_out(sum);
         MODE_NEG:  sample_in = sat_out(-sum);
         default:   sample_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (advance) begin
         out_sample_ff <= sample_in;
         out_last_ff   <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            k_ff         <= CNT_W'(1);
         end else if (advance && last) begin
            cur_valid_ff <= 1'b0;
         end else if (advance) begin
            k_ff <= k_ff + CNT_W'(1);
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;
   assign out_last   = out_last_ff;

endmodule

// File: hw/rtl/multiwave_lfo_generator.sv
// Path: a tick's first sample goes through the queue, current-ramp and output registers.
// Throughput: 16 samples per tick at one per cycle while the result side is popped,
//    set by the single interpolator in the back end; two ticks may wait in the queue.
// Reset: synchronous, active high; clears state, queue and output, loads default registers.
// ----------------------------------------------------------------------------
// Multiwave LFO generator
// Control ticks in, interpolated waveform samples out; front end advances
// the oscillator, back end interpolates the selected wave.
// ----------------------------------------------------------------------------
module multiwave_lfo_generator import lfo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_reset_gate,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [OUT_W-1:0] rsp_sample_value,
   output logic                    rsp_last_sample,
   input  logic                    valid,
   output logic                    ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   logic          accept;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   logic          out_valid;
   lfo_entry_type front_entry;
   lfo_entry_type q_entry;

   assign ready  = 1'b1;
   assign full   = q_full;
   assign accept = push && !q_full;
   assign empty  = !out_valid;

   lfo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .reset_gate (req_reset_gate),
      .entry      (front_entry)
   );

   lfo_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .din   (front_entry),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_entry),
      .empty (q_empty)
   );

   lfo_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .out_valid  (out_valid),
      .out_take   (pop),
      .out_sample (rsp_sample_value),
      .out_last   (rsp_last_sample)
   );

endmodule

// File: hw/rtl/lfo_checker.sv
// ----------------------------------------------------------------------------
// LFO port checker
// Watches the ports of the generator for framing and ordering slips.
// ----------------------------------------------------------------------------
`include "multiwave_lfo_generator_defines.svh"

module lfo_checker import lfo_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    push,
   input logic                    full,
   input logic                    empty,
   input logic                    pop,
   input logic signed [OUT_W-1:0] rsp_sample_value,
   input logic                    rsp_last_sample
);

   localparam int PEND_W = 3;

   logic                    in_xfer;
   logic                    out_xfer;
   logic [CHUNK_LOG2-1:0]   seen_ff, seen_in;
   logic [PEND_W-1:0]       pend_ff, pend_in;

   assign in_xfer  = push && !full;
   assign out_xfer = pop && !empty;

   always_comb begin
      seen_in = out_xfer ? seen_ff + CHUNK_LOG2'(1) : seen_ff;
      pend_in = pend_ff;
      if (in_xfer && !(out_xfer && rsp_last_sample)) begin
         pend_in = pend_ff + PEND_W'(1);
      end else if (!in_xfer && out_xfer && rsp_last_sample) begin
         pend_in = pend_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         pend_ff <= '0;
      end else begin
         seen_ff <= seen_in;
         pend_ff <= pend_in;
      end
   end

   `LFO_ASSERT_ALWAYS(a_empty_after_reset, reset |=> empty, "result side not empty after reset")
   `LFO_ASSERT(a_last_framing, out_xfer |-> (rsp_last_sample == (seen_ff == '1)), "last flag out of step with the chunk")
   `LFO_ASSERT(a_no_result_without_tick, !empty |-> (pend_ff != '0), "result with no tick in flight")
   `LFO_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(rsp_sample_value) && $stable(rsp_last_sample)), "waiting result changed")

endmodule

bind multiwave_lfo_generator lfo_checker u_lfo_checker (.*);
